@@ rtl/core/overwrite_oldest_message_ring_assert.svh @@
// Assertion macros used by the message ring checker.
`ifndef OVERWRITE_OLDEST_MESSAGE_RING_ASSERT_SVH
`define OVERWRITE_OLDEST_MESSAGE_RING_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OOMR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define OOMR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/oomr_pkg.sv @@
// Package for the message ring: widths, codes, and the front-to-back op type.
`default_nettype none

package oomr_pkg;

   // Default storage geometry
   localparam int DEPTH_DEFAULT      = 16;
   localparam int SLOT_BYTES_DEFAULT = 64;

   // Field widths
   localparam int CMD_W      = 1;
   localparam int DATA_W     = 8;
   localparam int LENGTH_W   = 16;
   localparam int LIMIT_W    = 16;
   localparam int STATUS_W   = 3;
   localparam int DLEN_W     = 7;
   localparam int OCC_W      = 5;
   localparam int CAP_W      = 5;
   localparam int SLOT_LEN_W = 7;

   // Config port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_LENGTH = 2'd1;
   localparam logic [CAP_W-1:0]      CAP_RESET      = 5'd16;
   localparam logic [SLOT_LEN_W-1:0] SLOT_LEN_RESET = 7'd64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   // Widest slot index and byte offset over the parameter range
   localparam int SLOT_IDX_MAX_W = 8;
   localparam int OFF_MAX_W      = 6;

   // Entries in the op queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_REJECTED    = 3'd0,
      ST_STORED      = 3'd1,
      ST_STORED_DROP = 3'd2,
      ST_EMPTY       = 3'd3,
      ST_BUSY        = 3'd4,
      ST_POPPED      = 3'd5
   } status_type;

   // One classified item, as handed from front to back
   typedef struct packed {
      logic                      pop_read;   // stream a stored message out
      status_type                status;
      logic [OCC_W-1:0]          occupancy;
      logic                      mem_wr;     // write one message byte
      logic                      len_wr;     // commit message length
      logic [SLOT_IDX_MAX_W-1:0] slot;
      logic [OFF_MAX_W-1:0]      offset;
      logic [DATA_W-1:0]         data;
      logic [SLOT_LEN_W-1:0]     length;
      logic [LIMIT_W-1:0]        limit;
   } op_type;

endpackage

`default_nettype wire

@@ rtl/core/oomr_if.sv @@
// Request and response channel interfaces of the message ring.
`default_nettype none

interface oomr_req_if;
   import oomr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [DATA_W-1:0]   data_in;
   logic [LENGTH_W-1:0] push_length;
   logic [LIMIT_W-1:0]  pop_limit;

   modport source (output valid, cmd, data_in, push_length, pop_limit, input ready);
   modport sink   (input valid, cmd, data_in, push_length, pop_limit, output ready);
endinterface

interface oomr_rsp_if;
   import oomr_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   data_out;
   logic                last_out;
   logic [DLEN_W-1:0]   delivered_length;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, data_out, last_out, delivered_length, occupancy,
                   input ready);
   modport sink   (input valid, status, data_out, last_out, delivered_length, occupancy,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/core/oomr_front.sv @@
// Front end: accepts items, tracks ring and open-message state, classifies each item.
`default_nettype none

module oomr_front #(
   parameter int DEPTH      = oomr_pkg::DEPTH_DEFAULT,
   parameter int SLOT_BYTES = oomr_pkg::SLOT_BYTES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   oomr_req_if.sink                              req_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [oomr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [oomr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output oomr_pkg::op_type                      q_wr_data,
   output logic                                  q_wr_en,
   input  wire logic                             q_full
);
   import oomr_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OFF_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int SUM_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   logic [CAP_W-1:0]      cap_reg_ff, cap_reg_in;
   logic [SLOT_LEN_W-1:0] slot_len_ff, slot_len_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  open_ff, open_in;
   logic                  disc_ff, disc_in;
   logic [LENGTH_W-1:0]   idx_ff, idx_in;
   logic [LENGTH_W-1:0]   total_ff, total_in;
   logic [IDX_W-1:0]      pslot_ff, pslot_in;

   logic                  accept;
   logic [SUM_W-1:0]      cap;
   logic [SUM_W-1:0]      slot_sum;
   logic [IDX_W-1:0]      new_slot;
   logic [SUM_W-1:0]      head_inc;
   logic [IDX_W-1:0]      head_next;
   logic                  disc_now;
   logic [LENGTH_W-1:0]   idx_now;
   logic [LENGTH_W-1:0]   total_now;
   logic [IDX_W-1:0]      slot_now;
   logic [LENGTH_W:0]     idx_inc;
   op_type                op;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Effective capacity and ring arithmetic
   always_comb begin
      if (cap_reg_ff == '0) begin
         cap = SUM_W'(1);
      end else if (SUM_W'(cap_reg_ff) > SUM_W'(DEPTH)) begin
         cap = SUM_W'(DEPTH);
      end else begin
         cap = SUM_W'(cap_reg_ff);
      end
      slot_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (slot_sum >= cap) begin
         slot_sum = slot_sum - cap;
      end
      new_slot = slot_sum[IDX_W-1:0];
      head_inc = SUM_W'(head_ff) + SUM_W'(1);
      if (head_inc >= cap) begin
         head_next = '0;
      end else begin
         head_next = head_inc[IDX_W-1:0];
      end
   end

   // Item classification and next state
   always_comb begin
      cap_reg_in  = cap_reg_ff;
      slot_len_in = slot_len_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      open_in     = open_ff;
      disc_in     = disc_ff;
      idx_in      = idx_ff;
      total_in    = total_ff;
      pslot_in    = pslot_ff;
      disc_now    = disc_ff;
      idx_now     = idx_ff;
      total_now   = total_ff;
      slot_now    = pslot_ff;
      idx_inc     = '0;
      op          = '0;
      op.status   = ST_REJECTED;

      if (accept) begin
         if (req_bus.cmd == CMD_PUSH) begin
            if (!open_ff && req_bus.push_length == '0) begin
               op.status = ST_REJECTED;
            end else begin
               // first byte opens the message
               if (!open_ff) begin
                  total_now = req_bus.push_length;
                  idx_now   = '0;
                  disc_now  = (req_bus.push_length > LENGTH_W'(slot_len_ff)) ||
                              (req_bus.push_length > LENGTH_W'(SLOT_BYTES));
                  slot_now  = new_slot;
               end
               op.status = disc_now ? ST_REJECTED : ST_STORED;
               op.mem_wr = !disc_now;
               op.slot   = SLOT_IDX_MAX_W'(slot_now);
               op.offset = OFF_MAX_W'(idx_now[OFF_W-1:0]);
               op.data   = req_bus.data_in;
               idx_inc   = {1'b0, idx_now} + (LENGTH_W+1)'(1);
               if (idx_inc >= {1'b0, total_now}) begin
                  // last byte closes the message and commits it unless it was discarded
                  if (!disc_now) begin
                     op.len_wr = 1'b1;
                     op.length = total_now[SLOT_LEN_W-1:0];
                     if (SUM_W'(count_ff) >= cap) begin
                        head_in   = head_next;
                        op.status = ST_STORED_DROP;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  open_in = 1'b0;
                  disc_in = 1'b0;
                  idx_in  = '0;
               end else begin
                  open_in  = 1'b1;
                  disc_in  = disc_now;
                  idx_in   = idx_inc[LENGTH_W-1:0];
                  total_in = total_now;
                  pslot_in = slot_now;
               end
            end
         end else begin
            if (open_ff) begin
               op.status = ST_BUSY;
            end else if (count_ff == '0) begin
               op.status = ST_EMPTY;
            end else begin
               op.status   = ST_POPPED;
               op.pop_read = 1'b1;
               op.slot     = SLOT_IDX_MAX_W'(head_ff);
               op.limit    = req_bus.pop_limit;
               head_in     = head_next;
               count_in    = count_ff - CNT_W'(1);
            end
         end
      end
      op.occupancy = OCC_W'(count_in);

      // register writes; a capacity write empties the ring
      if (csr_wr_en) begin
         case (csr_index)
            REG_CAPACITY: begin
               cap_reg_in = csr_wdata[CAP_W-1:0];
               head_in    = '0;
               count_in   = '0;
               open_in    = 1'b0;
               disc_in    = 1'b0;
               idx_in     = '0;
               total_in   = '0;
               pslot_in   = '0;
            end
            REG_SLOT_LENGTH: begin
               slot_len_in = csr_wdata[SLOT_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign q_wr_en   = accept;
   assign q_wr_data = op;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_reg_ff  <= CAP_RESET;
         slot_len_ff <= SLOT_LEN_RESET;
         head_ff     <= '0;
         count_ff    <= '0;
         open_ff     <= 1'b0;
         disc_ff     <= 1'b0;
         idx_ff      <= '0;
         total_ff    <= '0;
         pslot_ff    <= '0;
      end else begin
         cap_reg_ff  <= cap_reg_in;
         slot_len_ff <= slot_len_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         open_ff     <= open_in;
         disc_ff     <= disc_in;
         idx_ff      <= idx_in;
         total_ff    <= total_in;
         pslot_ff    <= pslot_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/oomr_queue.sv @@
// Short op queue that decouples the front end from the back end.
`default_nettype none

module oomr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire oomr_pkg::op_type  wr_data,
   output logic                   full,
   output logic                   rd_valid,
   output oomr_pkg::op_type       rd_data,
   input  wire logic              rd_en
);
   import oomr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/oomr_back.sv @@
// Back end: slot memories, pop streaming, and the two-stage response pipeline.
`default_nettype none

module oomr_back #(
   parameter int DEPTH      = oomr_pkg::DEPTH_DEFAULT,
   parameter int SLOT_BYTES = oomr_pkg::SLOT_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   input  wire oomr_pkg::op_type op,
   output logic                  op_take,
   oomr_rsp_if.source            rsp_bus
);
   import oomr_pkg::*;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OFF_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int MEM_N  = DEPTH * SLOT_BYTES;
   localparam int ADDR_W = (MEM_N > 1) ? $clog2(MEM_N) : 1;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LEN,
      BK_STREAM
   } state_type;

   // Slot storage
   logic [DATA_W-1:0]     byte_mem [MEM_N];
   logic [SLOT_LEN_W-1:0] len_mem  [DEPTH];
   logic [DATA_W-1:0]     byte_rd_ff;
   logic [SLOT_LEN_W-1:0] len_rd_ff;

   // Sequencer
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [DLEN_W-1:0]     n_ff, n_in;
   logic [DLEN_W-1:0]     i_ff, i_in;

   // Read stage and output stage
   logic                  r_vld_ff;
   status_type            r_status_ff, r_status_in;
   logic                  r_last_ff, r_last_in;
   logic [DLEN_W-1:0]     r_dl_ff, r_dl_in;
   logic [OCC_W-1:0]      r_occ_ff, r_occ_in;
   logic                  r_mem_ff, r_mem_in;
   logic                  o_vld_ff;
   status_type            o_status_ff;
   logic [DATA_W-1:0]     o_data_ff;
   logic                  o_last_ff;
   logic [DLEN_W-1:0]     o_dl_ff;
   logic [OCC_W-1:0]      o_occ_ff;

   logic                  o_load;
   logic                  r_free;
   logic                  r_issue;
   logic                  rd_en;
   logic [DLEN_W-1:0]     rd_idx;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [SLOT_LEN_W-1:0] len_cap;
   logic [DLEN_W-1:0]     n_calc;
   logic [DLEN_W-1:0]     i_inc;

   assign o_load = r_vld_ff && (!o_vld_ff || rsp_bus.ready);
   assign r_free = !r_vld_ff || o_load;
   assign i_inc  = i_ff + DLEN_W'(1);

   // Bytes delivered: stored length cut to the slot size and the limit
   always_comb begin
      len_cap = (len_rd_ff > SLOT_LEN_W'(SLOT_BYTES)) ? SLOT_LEN_W'(SLOT_BYTES) : len_rd_ff;
      n_calc  = (LIMIT_W'(len_cap) > limit_ff) ? limit_ff[DLEN_W-1:0] : DLEN_W'(len_cap);
   end

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      limit_in    = limit_ff;
      occ_in      = occ_ff;
      n_in        = n_ff;
      i_in        = i_ff;
      op_take     = 1'b0;
      r_issue     = 1'b0;
      rd_en       = 1'b0;
      rd_idx      = '0;
      r_status_in = ST_POPPED;
      r_last_in   = 1'b1;
      r_dl_in     = '0;
      r_occ_in    = occ_ff;
      r_mem_in    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (op_valid && r_free) begin
               op_take = 1'b1;
               if (op.pop_read) begin
                  slot_in  = op.slot[IDX_W-1:0];
                  limit_in = op.limit;
                  occ_in   = op.occupancy;
                  state_in = BK_LEN;
               end else begin
                  r_issue     = 1'b1;
                  r_status_in = op.status;
                  r_occ_in    = op.occupancy;
               end
            end
         end
         BK_LEN: begin
            if (r_free) begin
               r_issue = 1'b1;
               if (n_calc == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  n_in      = n_calc;
                  rd_en     = 1'b1;
                  r_last_in = (n_calc == DLEN_W'(1));
                  r_dl_in   = n_calc;
                  r_mem_in  = 1'b1;
                  i_in      = DLEN_W'(1);
                  state_in  = (n_calc == DLEN_W'(1)) ? BK_IDLE : BK_STREAM;
               end
            end
         end
         BK_STREAM: begin
            if (r_free) begin
               r_issue   = 1'b1;
               rd_en     = 1'b1;
               rd_idx    = i_ff;
               r_last_in = (i_inc == n_ff);
               r_dl_in   = n_ff;
               r_mem_in  = 1'b1;
               i_in      = i_inc;
               if (i_inc == n_ff) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rd_addr = ADDR_W'(slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_idx);
   assign wr_addr = ADDR_W'(op.slot[IDX_W-1:0]) * ADDR_W'(SLOT_BYTES) +
                    ADDR_W'(op.offset[OFF_W-1:0]);

   // Slot memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (op_take && op.mem_wr) begin
         byte_mem[wr_addr] <= op.data;
      end
      if (rd_en) begin
         byte_rd_ff <= byte_mem[rd_addr];
      end
      if (op_take && op.len_wr) begin
         len_mem[op.slot[IDX_W-1:0]] <= op.length;
      end
      if (op_take && op.pop_read) begin
         len_rd_ff <= len_mem[op.slot[IDX_W-1:0]];
      end
   end

   // Sequencer, read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         r_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         limit_ff <= limit_in;
         occ_ff   <= occ_in;
         n_ff     <= n_in;
         i_ff     <= i_in;
         if (r_issue) begin
            r_vld_ff    <= 1'b1;
            r_status_ff <= r_status_in;
            r_last_ff   <= r_last_in;
            r_dl_ff     <= r_dl_in;
            r_occ_ff    <= r_occ_in;
            r_mem_ff    <= r_mem_in;
         end else if (o_load) begin
            r_vld_ff <= 1'b0;
         end
         if (o_load) begin
            o_vld_ff    <= 1'b1;
            o_status_ff <= r_status_ff;
            o_data_ff   <= r_mem_ff ? byte_rd_ff : '0;
            o_last_ff   <= r_last_ff;
            o_dl_ff     <= r_dl_ff;
            o_occ_ff    <= r_occ_ff;
         end else if (rsp_bus.ready) begin
            o_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid            = o_vld_ff;
   assign rsp_bus.status           = o_status_ff;
   assign rsp_bus.data_out         = o_data_ff;
   assign rsp_bus.last_out         = o_last_ff;
   assign rsp_bus.delivered_length = o_dl_ff;
   assign rsp_bus.occupancy        = o_occ_ff;

endmodule

`default_nettype wire

@@ rtl/core/overwrite_oldest_message_ring.sv @@
// Overwrite-oldest message ring: push bytes in, pop whole messages out.
//
// Channels: req_bus carries one item per handshake: a push item moves one
// message byte (push_length is taken on the first byte of a message), a pop
// item asks for the oldest message cut to pop_limit. rsp_bus returns result
// items; a push or a refused pop gives one, a pop gives one per delivered byte
// with last_out on the final one. csr_* writes capacity or slot length while
// the block is idle; the user must keep to this, the block does not enforce
// it. A capacity write empties the ring. An accepted item passes the op
// queue, the read stage and the output register; a pop first reads its
// stored length. Throughput: one push byte per cycle unless the output
// stalls or a pop holds the back end for its length read and one slot memory
// read per byte. Reset clears front-end state, queue pointers, the back-end
// state register and valid flags; slot memories are not cleared and need no
// clearing pass. When the receiver stalls, the output register holds the
// item, the read stage and a two-entry op queue fill, and then req ready drops.
`default_nettype none

module overwrite_oldest_message_ring #(
   parameter int DEPTH      = oomr_pkg::DEPTH_DEFAULT,
   parameter int SLOT_BYTES = oomr_pkg::SLOT_BYTES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   oomr_req_if.sink                              req_bus,
   oomr_rsp_if.source                            rsp_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [oomr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [oomr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import oomr_pkg::*;

   op_type q_wr_data;
   op_type q_rd_data;
   logic   q_wr_en;
   logic   q_full;
   logic   q_rd_valid;
   logic   q_rd_en;

   oomr_front #(
      .DEPTH      (DEPTH),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_wr_data (q_wr_data),
      .q_wr_en   (q_wr_en),
      .q_full    (q_full)
   );

   oomr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr_en),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .rd_valid (q_rd_valid),
      .rd_data  (q_rd_data),
      .rd_en    (q_rd_en)
   );

   oomr_back #(
      .DEPTH      (DEPTH),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (q_rd_valid),
      .op       (q_rd_data),
      .op_take  (q_rd_en),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

@@ rtl/core/oomr_checker.sv @@
// Port-level checker for the message ring, bound to the top level.
`default_nettype none
`include "overwrite_oldest_message_ring_assert.svh"

module oomr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [oomr_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [oomr_pkg::DATA_W-1:0]   rsp_data_out,
   input wire logic                          rsp_last_out,
   input wire logic [oomr_pkg::DLEN_W-1:0]   rsp_delivered_length,
   input wire logic [oomr_pkg::OCC_W-1:0]    rsp_occupancy
);
   import oomr_pkg::*;

   // A stalled result holds
   `OOMR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_last_out) && $stable(rsp_delivered_length), "stalled result changed")

   // Anything but a popped byte is a single, empty result
   `OOMR_ASSERT_NOW(a_single_result, rsp_valid && rsp_status != ST_POPPED, rsp_last_out && rsp_data_out == '0 && rsp_delivered_length == '0, "non-pop result malformed")

   // A pop cut to zero bytes is one empty result
   `OOMR_ASSERT_NOW(a_zero_pop, rsp_valid && rsp_status == ST_POPPED && rsp_delivered_length == '0, rsp_last_out && rsp_data_out == '0, "zero-length pop malformed")

   // Dropping the oldest only happens with a full, non-empty ring
   `OOMR_ASSERT_NOW(a_drop_occupied, rsp_valid && rsp_status == ST_STORED_DROP, rsp_occupancy != '0, "drop reported with empty ring")

endmodule

bind overwrite_oldest_message_ring oomr_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_status           (rsp_bus.status),
   .rsp_data_out         (rsp_bus.data_out),
   .rsp_last_out         (rsp_bus.last_out),
   .rsp_delivered_length (rsp_bus.delivered_length),
   .rsp_occupancy        (rsp_bus.occupancy)
);

`default_nettype wire
